FILE: rtl/core/usbrh_pkg.sv
package usbrh_pkg;

   // port phases
   typedef enum logic [2:0] {
      PH_OFF,
      PH_POWERING,
      PH_WAITCONN,
      PH_RESET,
      PH_CONNECTED
   } phase_type;

   // event kinds on the request channel
   typedef enum logic [2:0] {
      EV_TICK,
      EV_CORE_STATUS,
      EV_SPEED,
      EV_HUB_REQUEST,
      EV_START,
      EV_STOP
   } func_type;

   // hub request kinds
   typedef enum logic [3:0] {
      RQ_HUB_STATUS,
      RQ_DESCRIPTOR,
      RQ_SET_HUB_FEAT,
      RQ_CLEAR_HUB_FEAT,
      RQ_SET_PORT_FEAT,
      RQ_CLEAR_PORT_FEAT,
      RQ_PORT_STATUS,
      RQ_POLL,
      RQ_OTHER
   } kind_type;

   // OTG states
   localparam logic [1:0] OTG_HOST     = 2'd0;
   localparam logic [1:0] OTG_WAITCONN = 2'd1;
   localparam logic [1:0] OTG_SUSPEND  = 2'd2;
   localparam logic [1:0] OTG_OTHER    = 2'd3;

   // speed codes
   localparam logic [1:0] SPD_LOW  = 2'd1;
   localparam logic [1:0] SPD_HIGH = 2'd2;

   // feature selectors
   localparam logic [7:0] FEAT_HUB_MAX      = 8'd1;
   localparam logic [7:0] FEAT_PORT_ENABLE  = 8'd1;
   localparam logic [7:0] FEAT_PORT_SUSPEND = 8'd2;
   localparam logic [7:0] FEAT_PORT_RESET   = 8'd4;
   localparam logic [7:0] FEAT_PORT_POWER   = 8'd8;
   localparam logic [7:0] FEAT_C_FIRST      = 8'd16;
   localparam logic [7:0] FEAT_C_LAST       = 8'd20;
   localparam logic [7:0] PORT_ONE          = 8'd1;

   // wPortStatus / wPortChange bits
   localparam logic [15:0] ST_CONNECTION = 16'h0001;
   localparam logic [15:0] ST_ENABLE     = 16'h0002;
   localparam logic [15:0] ST_RESET      = 16'h0010;
   localparam logic [15:0] ST_POWER      = 16'h0100;
   localparam logic [15:0] ST_LOW        = 16'h0200;
   localparam logic [15:0] ST_HIGH       = 16'h0400;
   localparam logic [15:0] CH_CONNECTION = 16'h0001;
   localparam logic [15:0] CH_RESET      = 16'h0010;

   localparam logic [15:0] TICKS_MAX = 16'hFFFF;

   // configuration register indexes
   localparam logic [7:0] CSR_RESET_TIMEOUT      = 8'd0;
   localparam logic [7:0] CSR_CORE_RESET_TIMEOUT = 8'd1;

   localparam logic [15:0] RESET_TIMEOUT_DEFAULT      = 16'd80;
   localparam logic [15:0] CORE_RESET_TIMEOUT_DEFAULT = 16'd1000;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   typedef struct packed {
      logic [15:0] reset_timeout;
      logic [15:0] core_reset_timeout;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] status;
      logic [15:0] prev_status;
      logic [15:0] change;
      logic [15:0] elapsed;
      logic        bus_request;
   } state_type;

   typedef struct packed {
      logic [2:0] func;
      logic [1:0] otg_mode;
      logic       core_reset_busy;
      logic [1:0] speed;
      logic [3:0] request_kind;
      logic [7:0] feature_selector;
      logic [7:0] port_number;
   } req_type;

   typedef struct packed {
      logic        stall_res;
      logic [15:0] port_status;
      logic [15:0] port_change;
      logic        change_pending;
      logic        bus_request;
      logic        start_port_reset;
      logic        core_reset;
      logic        power_retry;
      logic [2:0]  phase;
   } rsp_type;

endpackage

FILE: rtl/core/usbrh_step.sv
module usbrh_step (
   input  usbrh_pkg::state_type cur,
   input  usbrh_pkg::req_type   req,
   input  usbrh_pkg::cfg_type   cfg,
   output usbrh_pkg::state_type nxt,
   output usbrh_pkg::rsp_type   rsp
);
   import usbrh_pkg::*;

   logic [15:0] elapsed_inc;
   logic [15:0] status_diff;
   logic [15:0] change_noted;
   logic        tick_active;
   logic        core_timeout;
   logic        reset_timeout;
   logic        port_ok;
   logic        reset_req;
   func_type    func;
   kind_type    kind;

   assign func = func_type'(req.func);
   assign kind = kind_type'(req.request_kind);

   assign tick_active   = (cur.phase == PH_POWERING) || (cur.phase == PH_RESET);
   assign elapsed_inc   = (cur.elapsed < TICKS_MAX) ? cur.elapsed + 16'd1 : cur.elapsed;
   assign core_timeout  = (cur.phase == PH_POWERING) && (elapsed_inc >= cfg.core_reset_timeout);
   assign reset_timeout = (cur.phase == PH_RESET) && (elapsed_inc >= cfg.reset_timeout);

   assign status_diff  = cur.status ^ cur.prev_status;
   assign change_noted = cur.change
                       | ((status_diff & ST_CONNECTION) != 16'd0 ? CH_CONNECTION : 16'd0)
                       | ((status_diff & ST_RESET) != 16'd0 ? CH_RESET : 16'd0);

   assign port_ok = (req.port_number == PORT_ONE);

   // set port reset or clear port enable on port one
   assign reset_req = port_ok
      && (((kind == RQ_SET_PORT_FEAT) && (req.feature_selector == FEAT_PORT_RESET))
       || ((kind == RQ_CLEAR_PORT_FEAT) && (req.feature_selector == FEAT_PORT_ENABLE)));

   // next state
   always_comb begin
      nxt = cur;
      unique case (func)
         EV_TICK: begin
            if (tick_active) begin
               nxt.elapsed = elapsed_inc;
               if (core_timeout) begin
                  nxt.elapsed = 16'd0;
               end else if (reset_timeout) begin
                  nxt.status      = 16'd0;
                  nxt.bus_request = 1'b0;
                  nxt.elapsed     = 16'd0;
                  nxt.phase       = PH_POWERING;
               end
            end
         end
         EV_CORE_STATUS: begin
            unique case (cur.phase)
               PH_POWERING: begin
                  if (!req.core_reset_busy) begin
                     nxt.status      = ST_POWER;
                     nxt.bus_request = 1'b1;
                     nxt.elapsed     = 16'd0;
                     nxt.phase       = PH_WAITCONN;
                  end
               end
               PH_WAITCONN: begin
                  if (req.otg_mode == OTG_HOST) begin
                     nxt.status      = cur.status | ST_CONNECTION | ST_RESET | ST_ENABLE;
                     nxt.bus_request = 1'b0;
                     nxt.elapsed     = 16'd0;
                     nxt.phase       = PH_RESET;
                  end
               end
               PH_CONNECTED: begin
                  unique case (req.otg_mode)
                     OTG_WAITCONN: begin
                        nxt.status      = ST_POWER;
                        nxt.bus_request = 1'b1;
                        nxt.phase       = PH_WAITCONN;
                     end
                     OTG_SUSPEND: nxt.bus_request = 1'b1;
                     OTG_OTHER: begin
                        nxt.status      = 16'd0;
                        nxt.bus_request = 1'b0;
                        nxt.elapsed     = 16'd0;
                        nxt.phase       = PH_POWERING;
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
         EV_SPEED: begin
            if (cur.phase == PH_RESET) begin
               nxt.status = cur.status & ~(ST_RESET | ST_LOW | ST_HIGH);
               if (req.speed == SPD_HIGH) begin
                  nxt.status = nxt.status | ST_HIGH;
               end else if (req.speed == SPD_LOW) begin
                  nxt.status = nxt.status | ST_LOW;
               end
               nxt.elapsed = 16'd0;
               nxt.phase   = PH_CONNECTED;
            end
         end
         EV_HUB_REQUEST: begin
            if (reset_req && (cur.phase == PH_CONNECTED)) begin
               nxt.bus_request = 1'b0;
               nxt.status      = cur.status | ST_RESET | ST_ENABLE;
               nxt.elapsed     = 16'd0;
               nxt.phase       = PH_RESET;
            end else if ((kind == RQ_PORT_STATUS) && port_ok) begin
               nxt.prev_status = cur.status;
               nxt.change      = 16'd0;
            end else if (kind == RQ_POLL) begin
               nxt.prev_status = cur.status;
               nxt.change      = change_noted;
            end
         end
         EV_START: begin
            if (cur.phase == PH_OFF) begin
               nxt.elapsed = 16'd0;
               nxt.phase   = PH_POWERING;
            end
         end
         EV_STOP: begin
            if (cur.phase != PH_OFF) begin
               nxt.status      = 16'd0;
               nxt.bus_request = 1'b0;
               nxt.elapsed     = 16'd0;
               nxt.phase       = PH_OFF;
            end
         end
         default: ;
      endcase
   end

   // result fields
   always_comb begin
      rsp                  = '0;
      rsp.bus_request      = nxt.bus_request;
      rsp.phase            = nxt.phase;
      // bus reset is entered only from wait-for-connection or connected
      rsp.start_port_reset = (nxt.phase == PH_RESET) && (cur.phase != PH_RESET);
      rsp.power_retry      = (func == EV_TICK) && core_timeout;
      // powering is re-entered from a running phase only by a port reset timeout or an OTG_OTHER status while connected
      rsp.core_reset       = (nxt.phase == PH_OFF) || rsp.power_retry
                          || ((nxt.phase == PH_POWERING) && (cur.phase != PH_POWERING)
                              && (cur.phase != PH_OFF));
      if (func == EV_HUB_REQUEST) begin
         unique case (kind)
            RQ_HUB_STATUS, RQ_DESCRIPTOR: rsp.stall_res = 1'b0;
            RQ_SET_HUB_FEAT, RQ_CLEAR_HUB_FEAT:
               rsp.stall_res = (req.feature_selector > FEAT_HUB_MAX);
            RQ_SET_PORT_FEAT:
               rsp.stall_res = !port_ok
                  || !((req.feature_selector == FEAT_PORT_RESET)
                    || (req.feature_selector == FEAT_PORT_SUSPEND)
                    || (req.feature_selector == FEAT_PORT_POWER));
            RQ_CLEAR_PORT_FEAT:
               rsp.stall_res = !port_ok
                  || !((req.feature_selector == FEAT_PORT_ENABLE)
                    || (req.feature_selector == FEAT_PORT_SUSPEND)
                    || (req.feature_selector == FEAT_PORT_POWER)
                    || ((req.feature_selector >= FEAT_C_FIRST)
                        && (req.feature_selector <= FEAT_C_LAST)));
            RQ_PORT_STATUS: begin
               rsp.stall_res = !port_ok;
               if (port_ok) begin
                  rsp.port_status = cur.status;
                  rsp.port_change = change_noted;
               end
            end
            RQ_POLL: rsp.change_pending = (change_noted != 16'd0);
            default: rsp.stall_res = 1'b1;
         endcase
      end
   end

endmodule

FILE: rtl/core/usb_root_port_hotplug_fsm_core.sv
// Root-hub port state machine for a single-port USB host.
//
// Request channel (req_*): one event per transaction. req_tuser carries the
// event kind (tick, core status, speed report, hub request, start, stop);
// req_tdata carries the OTG state, core busy flag, speed and hub request.
// Response channel (rsp_*): exactly one result per event, in order, holding
// the stall flag, port status/change words, poll flag, bus request level,
// reset strobe, core reset level, retry strobe and the new phase.
// Config channel (csr_*): index 0 sets the port reset timeout, index 1 the
// core reset timeout, both in ticks; csr_ready is always high and writes are
// expected only while no event is in flight.
//
// The event is evaluated against the port state in the cycle it is accepted,
// and its result is registered. Throughput is one event per cycle while
// req_tready is high, set by the single state register update path.
// A two-entry output (result register plus skid register) lets one more event
// be accepted while the receiver stalls; req_tready drops only when both hold.
// Synchronous reset puts the port in the off phase with all status cleared,
// loads the default timeouts (80 and 1000 ticks) and empties the output.
module usb_root_port_hotplug_fsm_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [1:0] otg_mode, [2] core_reset_busy, [4:3] speed, [8:5] request_kind,
   // [16:9] feature_selector, [24:17] port_number, rest zero
   input  logic [usbrh_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [2:0] func
   input  logic [2:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] stall_res, [16:1] port_status, [32:17] port_change,
   // [33] change_pending, [34] bus_request, [35] start_port_reset,
   // [36] core_reset, [37] power_retry, [40:38] phase, rest zero
   output logic [usbrh_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [7:0]                          csr_index,
   input  logic [15:0]                         csr_data
);
   import usbrh_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   rsp_type   main_ff;
   rsp_type   skid_ff;
   logic      main_valid_ff;
   logic      skid_valid_ff;

   req_type   req;
   rsp_type   result;
   logic      req_accept;
   logic      rsp_pop;

   assign req.otg_mode         = req_tdata[1:0];
   assign req.core_reset_busy  = req_tdata[2];
   assign req.speed            = req_tdata[4:3];
   assign req.request_kind     = req_tdata[8:5];
   assign req.feature_selector = req_tdata[16:9];
   assign req.port_number      = req_tdata[24:17];
   assign req.func             = req_tuser;

   usbrh_step u_step (
      .cur (state_ff),
      .req (req),
      .cfg (cfg_ff),
      .nxt (state_in),
      .rsp (result)
   );

   assign req_tready = !skid_valid_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = rsp_tvalid && rsp_tready;
   assign csr_ready  = 1'b1;

   // config register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         if (csr_index == CSR_RESET_TIMEOUT) begin
            cfg_in.reset_timeout = csr_data;
         end else if (csr_index == CSR_CORE_RESET_TIMEOUT) begin
            cfg_in.core_reset_timeout = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_timeout      <= RESET_TIMEOUT_DEFAULT;
         cfg_ff.core_reset_timeout <= CORE_RESET_TIMEOUT_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // port state advances once per accepted event; all-zero state is the off phase
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // result register with skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_pop) begin
         if (skid_valid_ff) begin
            main_ff       <= skid_ff;
            skid_valid_ff <= 1'b0;
         end else if (req_accept) begin
            main_ff <= result;
         end else begin
            main_valid_ff <= 1'b0;
         end
      end else if (req_accept) begin
         if (!main_valid_ff) begin
            main_ff       <= result;
            main_valid_ff <= 1'b1;
         end else begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = {7'd0,
                        main_ff.phase,
                        main_ff.power_retry,
                        main_ff.core_reset,
                        main_ff.start_port_reset,
                        main_ff.bus_request,
                        main_ff.change_pending,
                        main_ff.port_change,
                        main_ff.port_status,
                        main_ff.stall_res};

endmodule

FILE: rtl/core/usbrh_checker.sv
module usbrh_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [usbrh_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import usbrh_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // off phase always holds the core in reset
   a_off_core_reset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[40:38] == PH_OFF) |-> rsp_tdata[36])
      else $error("core not held in reset while off");

   // reset strobe lands in the port reset phase with bus request dropped
   a_strobe_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |-> (rsp_tdata[40:38] == PH_RESET) && !rsp_tdata[34])
      else $error("reset strobe outside port reset");

   // retry strobe pulses core reset and stays in powering
   a_retry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[37] |-> rsp_tdata[36] && (rsp_tdata[40:38] == PH_POWERING))
      else $error("retry strobe without core reset pulse");

   // port status words only travel on non-stalled results
   a_status_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> (rsp_tdata[32:1] == 32'd0) && !rsp_tdata[33])
      else $error("stalled request returned status");

endmodule

bind usb_root_port_hotplug_fsm_core usbrh_checker u_usbrh_checker (.*);
